// File: design/ppc_pkg.sv
// Shared types and constants of the PID position controller.
// Used by ppc_const_div and pid_position_controller; depends on nothing.
package ppc_pkg;

    // Default sizes of the position input and the integral accumulator
    localparam int POSITION_WIDTH_DEFAULT    = 16;
    localparam int ACCUMULATOR_WIDTH_DEFAULT = 32;

    // Fixed field widths
    localparam int DATA_WIDTH       = 16;   // setpoint, limits, excitation
    localparam int GAIN_WIDTH       = 15;
    localparam int GAIN_I3_WIDTH    = 17;   // gain_i * 3
    localparam int GAIN_D_SC_WIDTH  = 25;   // gain_d * 1000
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int SCALED_WIDTH     = 12;   // clamped integral term, +-1024

    // Loop constants
    localparam int DEAD_OFFSET = 150;
    localparam int INTEG_LIMIT = 1024;
    localparam int INTEG_SHIFT = 10;
    localparam int D_SCALE     = 1000;
    localparam int POS_DIV     = 5;
    localparam int HALF_PERIOD = 3;
    localparam int PERIOD      = 6;

    // Register reset values
    localparam int TARGET_RESET    = 0;
    localparam int GAIN_P_RESET    = 20;
    localparam int GAIN_I_RESET    = 5;
    localparam int GAIN_D_RESET    = 0;
    localparam int DRIVE_MAX_RESET = 1023;
    localparam int DRIVE_MIN_RESET = -1023;

    // Input transaction kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_TARGET    = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_DRIVE_MAX = 3'd4,
        REG_DRIVE_MIN = 3'd5
    } cfg_reg_t;

    // Stage loads of the constant divider
    typedef struct packed {
        logic mul;   // load the reciprocal product
        logic fix;   // load the signed quotient
    } div_en_t;

endpackage

// File: design/ppc_const_div.sv
// Two-stage signed division by a constant, truncating toward zero.
// Reciprocal multiply on the magnitude, then sign restore. Uses ppc_pkg.
module ppc_const_div import ppc_pkg::*; #(
    parameter int IN_WIDTH = POSITION_WIDTH_DEFAULT,
    parameter int DIVISOR  = POS_DIV
) (
    input  logic                       aclk,
    input  div_en_t                    en,
    input  logic signed [IN_WIDTH-1:0] x,
    output logic signed [IN_WIDTH-1:0] q
);

    // Exact for every magnitude below 2**IN_WIDTH with this shift
    localparam int SHIFT    = IN_WIDTH + $clog2(DIVISOR);
    localparam int RECIP_W  = IN_WIDTH + 1;
    localparam int PROD_W   = IN_WIDTH + RECIP_W;
    localparam int QUOT_W   = PROD_W - SHIFT;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR);

    logic [IN_WIDTH-1:0]        x_mag;
    logic [PROD_W-1:0]          prod_next;
    logic [PROD_W-1:0]          prod_reg;
    logic                       neg_reg;
    logic signed [QUOT_W:0]     quot;
    logic signed [IN_WIDTH-1:0] q_next;
    logic signed [IN_WIDTH-1:0] q_reg;

    assign x_mag     = x[IN_WIDTH-1] ? IN_WIDTH'(-x) : IN_WIDTH'(x);
    assign prod_next = PROD_W'(x_mag) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            prod_reg <= prod_next;
            neg_reg  <= x[IN_WIDTH-1];
        end
    end

    assign quot   = {1'b0, prod_reg[PROD_W-1:SHIFT]};
    assign q_next = neg_reg ? IN_WIDTH'(-quot) : IN_WIDTH'(quot);

    always_ff @(posedge aclk) begin
        if (en.fix) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: design/pid_position_controller.sv
// PID position controller top level: eight-stage pipeline from input register to
// result register, configuration registers and loop state. Uses ppc_pkg, ppc_const_div.
//
// Takes one transaction per clock when the result side keeps up. A tick transaction
// presents its excitation on the result port once it reaches the result register; a
// clear transaction yields no result and takes effect on the loop state as it passes
// the pipeline, in order with the ticks around it. The one-per-cycle rate is held by
// the integral accumulator, whose saturating add closes on itself within stage 5;
// the divides by 5 and 6 and the gain products sit in earlier stages. A stalled result
// register backs up stage by stage, so empty stages still fill while the output waits.
// Write configuration only while the pipeline is empty.
module pid_position_controller import ppc_pkg::*; #(
    parameter int POSITION_WIDTH    = POSITION_WIDTH_DEFAULT,
    parameter int ACCUMULATOR_WIDTH = ACCUMULATOR_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]       cfg_wr_index,
    input  logic [DATA_WIDTH-1:0]            cfg_wr_data,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_kind,
    input  logic signed [POSITION_WIDTH-1:0] s_position,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [DATA_WIDTH-1:0]     m_excitation
);

    localparam int PW     = POSITION_WIDTH;
    localparam int AW     = ACCUMULATOR_WIDTH;
    localparam int NSTAGE = 8;
    localparam int DW     = PW + 1;                                    // position delta
    localparam int EW     = ((PW > DATA_WIDTH) ? PW : DATA_WIDTH) + 1; // error
    localparam int ESW    = EW + 1;                                    // error pair sum
    localparam int IW     = ESW + GAIN_I3_WIDTH + 1;                   // integral step
    localparam int PTW    = EW + GAIN_WIDTH + 1;                       // P term
    localparam int DTW    = DW + GAIN_D_SC_WIDTH + 1;                  // D term
    localparam int SW     = ((AW > IW) ? AW : IW) + 1;
    localparam int ACTW   = ((PTW > DTW) ? PTW : DTW) + 2;
    localparam int OW     = DATA_WIDTH + 1;

    localparam logic signed [AW-1:0] INT_HI = AW'(INTEG_LIMIT);
    localparam logic signed [AW-1:0] INT_LO = AW'(-INTEG_LIMIT);
    localparam logic signed [OW-1:0] OFFSET = OW'(DEAD_OFFSET);

    // ---------------- configuration ----------------
    logic signed [DATA_WIDTH-1:0]  target_reg;
    logic [GAIN_WIDTH-1:0]         gain_p_reg;
    logic [GAIN_I3_WIDTH-1:0]      gain_i3_reg;
    logic [GAIN_D_SC_WIDTH-1:0]    gain_d_sc_reg;
    logic signed [DATA_WIDTH-1:0]  drive_max_reg;
    logic signed [DATA_WIDTH-1:0]  drive_min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= DATA_WIDTH'(TARGET_RESET);
            gain_p_reg    <= GAIN_WIDTH'(GAIN_P_RESET);
            gain_i3_reg   <= GAIN_I3_WIDTH'(GAIN_I_RESET * HALF_PERIOD);
            gain_d_sc_reg <= GAIN_D_SC_WIDTH'(GAIN_D_RESET * D_SCALE);
            drive_max_reg <= DATA_WIDTH'(DRIVE_MAX_RESET);
            drive_min_reg <= DATA_WIDTH'(DRIVE_MIN_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_wr_index))
                REG_TARGET:    target_reg <= cfg_wr_data;
                REG_GAIN_P:    gain_p_reg <= cfg_wr_data[GAIN_WIDTH-1:0];
                // fold the fixed factors into the stored gains
                REG_GAIN_I:    gain_i3_reg <= GAIN_I3_WIDTH'(cfg_wr_data[GAIN_WIDTH-1:0])
                                            * GAIN_I3_WIDTH'(HALF_PERIOD);
                REG_GAIN_D:    gain_d_sc_reg <=
                                   GAIN_D_SC_WIDTH'(cfg_wr_data[GAIN_WIDTH-1:0])
                                   * GAIN_D_SC_WIDTH'(D_SCALE);
                REG_DRIVE_MAX: drive_max_reg <= cfg_wr_data;
                REG_DRIVE_MIN: drive_min_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_next;
    logic [NSTAGE-1:0] vin;
    logic [NSTAGE-1:0] en;
    logic              ig_kind_reg;

    always_comb begin
        en[NSTAGE-1] = !v_reg[NSTAGE-1] || m_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_comb begin
        vin    = {v_reg[NSTAGE-2:0], s_valid};
        // drop clear transactions once the integral has seen them
        vin[6] = v_reg[5] && (ig_kind_reg != KIND_CLEAR);
        v_next = (en & vin) | (~en & v_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[0];

    logic xfer1, xfer3, xfer5;
    assign xfer1 = en[1] && v_reg[0];
    assign xfer3 = en[3] && v_reg[2];
    assign xfer5 = en[5] && v_reg[4];

    // ---------------- stage 0: input register ----------------
    logic                 in_kind_reg;
    logic signed [PW-1:0] in_pos_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            in_kind_reg <= s_kind;
            in_pos_reg  <= s_position;
        end
    end

    // ---------------- stages 1-2: divides ----------------
    logic signed [PW-1:0] last_pos_reg;
    logic signed [DW-1:0] pos_delta;
    logic signed [PW-1:0] q5;
    logic signed [DW-1:0] q6;
    logic                 dv_kind_reg;
    logic                 qt_kind_reg;
    div_en_t              div_en;

    assign pos_delta = DW'(last_pos_reg) - DW'(in_pos_reg);
    assign div_en    = '{mul: en[1], fix: en[2]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pos_reg <= '0;
        end else if (xfer1 && in_kind_reg == KIND_TICK) begin
            last_pos_reg <= in_pos_reg;
        end
    end

    ppc_const_div #(.IN_WIDTH(PW), .DIVISOR(POS_DIV)) u_div_pos (
        .aclk (aclk),
        .en   (div_en),
        .x    (in_pos_reg),
        .q    (q5)
    );

    ppc_const_div #(.IN_WIDTH(DW), .DIVISOR(PERIOD)) u_div_delta (
        .aclk (aclk),
        .en   (div_en),
        .x    (pos_delta),
        .q    (q6)
    );

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            dv_kind_reg <= in_kind_reg;
        end
        if (en[2]) begin
            qt_kind_reg <= dv_kind_reg;
        end
    end

    // ---------------- stage 3: error ----------------
    logic signed [EW-1:0]  err_next;
    logic signed [ESW-1:0] errsum_next;
    logic signed [EW-1:0]  last_err_reg;
    logic                  er_kind_reg;
    logic signed [EW-1:0]  er_err_reg;
    logic signed [ESW-1:0] er_errsum_reg;
    logic signed [DW-1:0]  er_q6_reg;

    assign err_next    = -EW'(target_reg) - EW'(q5);
    assign errsum_next = ESW'(err_next) + ESW'(last_err_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
        end else if (xfer3) begin
            last_err_reg <= (qt_kind_reg == KIND_CLEAR) ? '0 : err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            er_kind_reg   <= qt_kind_reg;
            er_err_reg    <= err_next;
            er_errsum_reg <= errsum_next;
            er_q6_reg     <= q6;
        end
    end

    // ---------------- stage 4: gain products ----------------
    logic signed [GAIN_I3_WIDTH:0]   gain_i3_s;
    logic signed [GAIN_WIDTH:0]      gain_p_s;
    logic signed [GAIN_D_SC_WIDTH:0] gain_d_s;
    logic                            ml_kind_reg;
    logic signed [IW-1:0]            ml_incr_reg;
    logic signed [PTW-1:0]           ml_p_reg;
    logic signed [DTW-1:0]           ml_d_reg;

    assign gain_i3_s = {1'b0, gain_i3_reg};
    assign gain_p_s  = {1'b0, gain_p_reg};
    assign gain_d_s  = {1'b0, gain_d_sc_reg};

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            ml_kind_reg <= er_kind_reg;
            ml_incr_reg <= IW'(er_errsum_reg) * IW'(gain_i3_s);
            ml_p_reg    <= PTW'(er_err_reg) * PTW'(gain_p_s);
            ml_d_reg    <= DTW'(er_q6_reg) * DTW'(gain_d_s);
        end
    end

    // ---------------- stage 5: integral ----------------
    logic signed [AW-1:0]  integral_reg;
    logic signed [AW-1:0]  integral_next;
    logic signed [SW-1:0]  integ_sum;
    logic                  integ_ovf;
    logic signed [PTW-1:0] ig_p_reg;
    logic signed [DTW-1:0] ig_d_reg;

    assign integ_sum = SW'(integral_reg) + SW'(ml_incr_reg);
    assign integ_ovf = !((&integ_sum[SW-1:AW-1]) || !(|integ_sum[SW-1:AW-1]));

    always_comb begin
        if (ml_kind_reg == KIND_CLEAR) begin
            integral_next = '0;
        end else if (integ_ovf) begin
            integral_next = integ_sum[SW-1] ? {1'b1, {(AW-1){1'b0}}}
                                            : {1'b0, {(AW-1){1'b1}}};
        end else begin
            integral_next = integ_sum[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
        end else if (xfer5) begin
            integral_reg <= integral_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            ig_kind_reg <= ml_kind_reg;
            ig_p_reg    <= ml_p_reg;
            ig_d_reg    <= ml_d_reg;
        end
    end

    // ---------------- stage 6: activation ----------------
    logic signed [AW-1:0]           integ_shift;
    logic signed [SCALED_WIDTH-1:0] scaled;
    logic signed [ACTW-1:0]         act_full;
    logic                           act_ovf;
    logic signed [DATA_WIDTH-1:0]   act_next;
    logic signed [DATA_WIDTH-1:0]   act_reg;

    // integral_reg holds the value left by the transaction now in stage 5
    assign integ_shift = integral_reg >>> INTEG_SHIFT;

    always_comb begin
        if (integ_shift > INT_HI) begin
            scaled = SCALED_WIDTH'(INT_HI);
        end else if (integ_shift < INT_LO) begin
            scaled = SCALED_WIDTH'(INT_LO);
        end else begin
            scaled = SCALED_WIDTH'(integ_shift);
        end
    end

    assign act_full = ACTW'(ig_p_reg) + ACTW'(ig_d_reg) + ACTW'(scaled);
    assign act_ovf  = !((&act_full[ACTW-1:DATA_WIDTH-1])
                        || !(|act_full[ACTW-1:DATA_WIDTH-1]));
    assign act_next = act_ovf ? (act_full[ACTW-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                                  : {1'b0, {(DATA_WIDTH-1){1'b1}}})
                              : act_full[DATA_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            act_reg <= act_next;
        end
    end

    // ---------------- stage 7: dead-zone offset and limits ----------------
    logic signed [OW-1:0]         act_ext;
    logic signed [OW-1:0]         offs;
    logic signed [OW-1:0]         lim_hi;
    logic signed [OW-1:0]         lim_lo;
    logic signed [OW-1:0]         clip_hi;
    logic signed [OW-1:0]         clip_lo;
    logic signed [DATA_WIDTH-1:0] exc_reg;

    assign act_ext = OW'(act_reg);
    assign lim_hi  = OW'(drive_max_reg);
    assign lim_lo  = OW'(drive_min_reg);

    always_comb begin
        if (act_reg > 0) begin
            offs = act_ext + OFFSET;
        end else if (act_reg < 0) begin
            offs = act_ext - OFFSET;
        end else begin
            offs = act_ext;
        end
        // upper limit first, so crossed limits give the lower one
        clip_hi = (offs > lim_hi) ? lim_hi : offs;
        clip_lo = (clip_hi < lim_lo) ? lim_lo : clip_hi;
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            exc_reg <= clip_lo[DATA_WIDTH-1:0];
        end
    end

    assign m_valid      = v_reg[NSTAGE-1];
    assign m_excitation = exc_reg;

    // ---------------- assertions ----------------
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[NSTAGE-1] |-> s_ready)
        else $error("input stalled with an empty result register");

    a_clear_zeroes_integral: assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer5 && ml_kind_reg == KIND_CLEAR) |=> (integral_reg == '0))
        else $error("clear did not zero the integral");

    a_clear_zeroes_last_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer3 && qt_kind_reg == KIND_CLEAR) |=> (last_err_reg == '0))
        else $error("clear did not zero the previous error");

    a_output_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && drive_min_reg <= drive_max_reg)
        |-> (m_excitation <= drive_max_reg && m_excitation >= drive_min_reg))
        else $error("excitation outside the drive limits");

endmodule

// File: tb/pid_position_controller_test.sv
// Self-checking testbench for pid_position_controller: an excitation scoreboard predicts
// every tick from its own copy of the registers and loop state. Depends on ppc_pkg and the RTL.
module pid_position_controller_test import ppc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W           = POSITION_WIDTH_DEFAULT;
    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 11;
    localparam int PIPE_SETTLE     = 16;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_LIMIT     = 100000;
    localparam int WATCHDOG_CYCLES = 1000000;
    localparam int MAX_PRINTED     = 100;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

    localparam longint ACC_MAX = (longint'(1) <<< (ACCUMULATOR_WIDTH_DEFAULT - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint EXC_MAX = 32767;
    localparam longint EXC_MIN = -32768;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    class excitation_scoreboard;
        logic signed [DATA_WIDTH-1:0] target_angle;
        logic        [GAIN_WIDTH-1:0] gain_p;
        logic        [GAIN_WIDTH-1:0] gain_i;
        logic        [GAIN_WIDTH-1:0] gain_d;
        logic signed [DATA_WIDTH-1:0] drive_max;
        logic signed [DATA_WIDTH-1:0] drive_min;

        longint integral_sum;
        longint last_error;
        longint last_position;

        logic signed [DATA_WIDTH-1:0] excitation_q[$];
        int errors;
        int checked;
        int ticks;
        int clears;

        function new();
            target_angle  = TARGET_RESET;
            gain_p        = GAIN_P_RESET;
            gain_i        = GAIN_I_RESET;
            gain_d        = GAIN_D_RESET;
            drive_max     = DRIVE_MAX_RESET;
            drive_min     = DRIVE_MIN_RESET;
            integral_sum  = 0;
            last_error    = 0;
            last_position = 0;
            errors        = 0;
            checked       = 0;
            ticks         = 0;
            clears        = 0;
        endfunction

        function int pending();
            return excitation_q.size();
        endfunction

        function void write_register(logic [CFG_INDEX_WIDTH-1:0] index,
                                     logic [DATA_WIDTH-1:0] value);
            case (index)
                REG_TARGET:    target_angle = value;
                REG_GAIN_P:    gain_p = value[GAIN_WIDTH-1:0];
                REG_GAIN_I:    gain_i = value[GAIN_WIDTH-1:0];
                REG_GAIN_D:    gain_d = value[GAIN_WIDTH-1:0];
                REG_DRIVE_MAX: drive_max = value;
                REG_DRIVE_MIN: drive_min = value;
                default: ;
            endcase
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Advance the loop state by one accepted transaction.
        task note_input(logic kind, logic signed [POS_W-1:0] position);
            longint pos;
            longint err;
            longint scaled;
            longint act;
            longint exc;
            if (kind == KIND_CLEAR) begin
                integral_sum = 0;
                last_error   = 0;
                clears++;
                return;
            end
            pos = position;
            err = -longint'(target_angle) - pos / POS_DIV;

            integral_sum = integral_sum + longint'(gain_i) * HALF_PERIOD * (err + last_error);
            if (integral_sum > ACC_MAX) integral_sum = ACC_MAX;
            else if (integral_sum < ACC_MIN) integral_sum = ACC_MIN;

            scaled = integral_sum >>> INTEG_SHIFT;
            if (scaled > INTEG_LIMIT) scaled = INTEG_LIMIT;
            else if (scaled < -INTEG_LIMIT) scaled = -INTEG_LIMIT;

            act = longint'(gain_p) * err
                + longint'(gain_d) * D_SCALE * ((last_position - pos) / PERIOD)
                + scaled;
            if (act > EXC_MAX) act = EXC_MAX;
            else if (act < EXC_MIN) act = EXC_MIN;

            // dead-zone offset away from zero, then upper clamp before lower clamp
            exc = act;
            if (exc > 0) exc = exc + DEAD_OFFSET;
            else if (exc < 0) exc = exc - DEAD_OFFSET;
            if (exc > longint'(drive_max)) exc = drive_max;
            if (exc < longint'(drive_min)) exc = drive_min;

            excitation_q.push_back(exc[DATA_WIDTH-1:0]);
            last_error    = err;
            last_position = pos;
            ticks++;
        endtask

        task check_result(logic signed [DATA_WIDTH-1:0] excitation);
            logic signed [DATA_WIDTH-1:0] want;
            checked++;
            if (excitation_q.size() == 0) begin
                report($sformatf("excitation %0d arrived with no tick waiting", excitation));
            end else begin
                want = excitation_q.pop_front();
                if (excitation !== want)
                    report($sformatf("excitation %0d, expected %0d (result %0d)",
                                     excitation, want, checked));
            end
        endtask

        task flush_leftovers();
            while (excitation_q.size() != 0)
                report($sformatf("tick never answered, expected excitation %0d",
                                 excitation_q.pop_front()));
        endtask
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [CFG_INDEX_WIDTH-1:0]       cfg_wr_index;
    logic [DATA_WIDTH-1:0]            cfg_wr_data;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_kind;
    logic signed [POS_W-1:0]          s_position;
    logic                             m_valid;
    logic                             m_ready;
    logic signed [DATA_WIDTH-1:0]     m_excitation;

    excitation_scoreboard sb = new();

    bit send_jitter;
    bit recv_jitter;
    bit long_hold_req;
    int settings_applied;

    pid_position_controller dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_excitation (m_excitation)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (m_valid && m_ready) sb.check_result(m_excitation);
            if (s_valid && s_ready) sb.note_input(s_kind, s_position);
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_idle();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return 0;
        if (sel < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    function automatic logic signed [POS_W-1:0] pick_position(logic signed [POS_W-1:0] prev);
        int sel;
        int step;
        sel = $urandom_range(99);
        if (sel < 35) return POS_W'($urandom);
        if (sel < 70) begin
            step = int'($urandom_range(200)) - 100;
            return POS_W'(prev + step);
        end
        if (sel < 88) return POS_W'(int'($urandom_range(24)) - 12);
        case ($urandom_range(3))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return POS_W'(POS_MAX - 1);
            default: return POS_W'(POS_MIN + 1);
        endcase
    endfunction

    // Receiver: random back-pressure, plus one long hold on request.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (!recv_jitter || $urandom_range(99) < 65) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (pick_idle()) @(negedge aclk);
            end
        end
    end

    task automatic send_item(input logic kind, input logic signed [POS_W-1:0] pos);
        int gap;
        gap = send_jitter ? pick_idle() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid    <= 1'b0;
            s_kind     <= 1'($urandom);
            s_position <= POS_W'($urandom);
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [DATA_WIDTH-1:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        sb.write_register(index, value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    // Drop valid, wait for every expected excitation, then let clears flush out.
    task automatic wait_idle(input int limit);
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0 && waited < limit) begin
            @(negedge aclk);
            waited++;
        end
        sb.flush_leftovers();
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    task automatic apply_setting(input logic [DATA_WIDTH-1:0] target,
                                 input logic [DATA_WIDTH-1:0] kp,
                                 input logic [DATA_WIDTH-1:0] ki,
                                 input logic [DATA_WIDTH-1:0] kd,
                                 input logic [DATA_WIDTH-1:0] upper,
                                 input logic [DATA_WIDTH-1:0] lower);
        wait_idle(DRAIN_LIMIT);
        write_reg(REG_TARGET, target);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_DRIVE_MAX, upper);
        write_reg(REG_DRIVE_MIN, lower);
        settings_applied++;
    endtask

    logic signed [POS_W-1:0] prev_position;

    task automatic run_random(input int count, input int clear_pct);
        logic kind;
        logic signed [POS_W-1:0] pos;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                send_jitter = ($urandom_range(3) != 0);
                recv_jitter = ($urandom_range(3) != 0);
            end
            kind = ($urandom_range(99) < clear_pct) ? KIND_CLEAR : KIND_TICK;
            pos  = pick_position(prev_position);
            send_item(kind, pos);
            if (kind == KIND_TICK) prev_position = pos;
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = '0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_kind        = KIND_TICK;
        s_position    = '0;
        m_ready       = 1'b0;
        send_jitter   = 1'b0;
        recv_jitter   = 1'b0;
        long_hold_req = 1'b0;
        prev_position = '0;
        settings_applied = 1;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset gains, truncation around the divisors, extremes, clears.
        send_item(KIND_TICK, 0);
        send_item(KIND_TICK, 4);
        send_item(KIND_TICK, -4);
        send_item(KIND_TICK, 5);
        send_item(KIND_TICK, -5);
        send_item(KIND_TICK, 6);
        send_item(KIND_TICK, -6);
        send_item(KIND_TICK, -7);
        send_item(KIND_TICK, POS_MAX);
        send_item(KIND_TICK, POS_MIN);
        send_item(KIND_TICK, 1);
        send_item(KIND_TICK, -1);
        send_item(KIND_CLEAR, 16'sh5555);
        send_item(KIND_TICK, 0);
        send_item(KIND_TICK, 3);
        send_item(KIND_TICK, 100);
        send_item(KIND_CLEAR, 16'shAAAA);
        send_item(KIND_TICK, 100);
        send_item(KIND_TICK, POS_MIN);
        send_item(KIND_TICK, POS_MAX);
        wait_idle(DRAIN_LIMIT);

        // Writes to unmapped indexes must not disturb anything.
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h8000);
        prev_position = '0;
        run_random(150, 5);

        // Full gains and widest limits: activation saturates.
        apply_setting(0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        run_random(150, 5);

        // Integral-driven: positive, then negative accumulator saturation (the second with a P gain of 1).
        apply_setting(16'h8000, 0, 16'h7FFF, 0, 16'h7FFF, 16'h8000);
        run_random(100, 0);
        apply_setting(16'h7FFF, 1, 16'h7FFF, 0, 16'h7FFF, 16'h8000);
        run_random(100, 2);

        // Crossed limits: output pinned at drive_min.
        apply_setting(50, 20, 5, 3, -200, 200);
        run_random(100, 5);

        // Derivative only: zero activation is common.
        apply_setting(0, 0, 0, 1, 400, -400);
        run_random(100, 5);

        // Both limits at one extreme, then the other.
        apply_setting(1000, 2, 9, 1, 16'h8000, 16'h8000);
        run_random(50, 5);
        apply_setting(16'hFC18, 2, 9, 1, 16'h7FFF, 16'h7FFF);
        run_random(50, 5);

        // Long receiver hold while the sender keeps offering: the pipe backs up.
        apply_setting(16'h0123, 40, 11, 2, 2000, -2000);
        send_jitter   = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 80; i++) begin
            prev_position = pick_position(prev_position);
            send_item(($urandom_range(9) == 0) ? KIND_CLEAR : KIND_TICK, prev_position);
        end

        repeat (3) begin
            apply_setting(DATA_WIDTH'($urandom), DATA_WIDTH'($urandom),
                          DATA_WIDTH'($urandom), DATA_WIDTH'($urandom),
                          DATA_WIDTH'($urandom), DATA_WIDTH'($urandom));
            run_random(100, 5);
        end

        wait_idle(DRAIN_LIMIT);

        $display("Ran %0d ticks and %0d clears under %0d register settings;",
                 sb.ticks, sb.clears, settings_applied);
        $display("checked %0d excitations, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("** pid_position_controller: PASSED **");
        else
            $display("** pid_position_controller: FAILED **");
        $finish;
    end

    initial begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("Timeout: run did not complete.");
        $display("** pid_position_controller: FAILED **");
        $finish;
    end

endmodule
